[rtl/core/fpd_pkg.sv]
// Shared types, constants and the byte-wide CRC-16 update for the frame deframer.
// Used by fpd_parser and framed_packet_deframer_crc16; depends on nothing else.
`default_nettype none

package fpd_pkg;

  localparam int BUFFER_BYTES = 8208;
  localparam int MIN_LENGTH   = 3;
  localparam int MAX_LENGTH   = BUFFER_BYTES - 2;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_FOOTER = 2'd3;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_PAYLOAD  = 3'd1;
  localparam logic [2:0] EV_GOOD     = 3'd2;
  localparam logic [2:0] EV_FOOTER   = 3'd3;
  localparam logic [2:0] EV_CRC      = 3'd4;
  localparam logic [2:0] EV_REJECTED = 3'd5;

  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_FOOTER = 2'd1;
  localparam logic [1:0] REG_SEED   = 2'd2;

  typedef struct packed {
    logic [15:0] header_word;
    logic [15:0] footer_word;
    logic [15:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  payload_byte;
    logic [13:0] payload_index;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/framed_packet_deframer_crc16.sv]
// Top level of the length-prefixed frame deframer with CRC-16 check.
// Holds the stream registers and the configuration port; uses fpd_pkg and fpd_parser.
//
// The block takes one received byte per item and returns exactly one result item
// per input item. It sustains one item per clock cycle while the output side is
// ready; out_tready low stalls it. Each byte passes from the input register through
// the parser step, whose longest path is the byte-wide CRC-16 update, into the
// output register. Configuration registers should be written only while no item
// is in flight.
`default_nettype none

module framed_packet_deframer_crc16 #(
  parameter int BUFFER_BYTES = fpd_pkg::BUFFER_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] payload_byte, [21:8] payload_index,
                                       // [29:22] frame_type, [45:30] frame_length, rest 0
  output logic [2:0]       out_tuser,  // [2:0] event_kind
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic          in_vld_r;
  logic [7:0]    in_byte_r;
  logic          in_restart_r;
  logic          out_vld_r;
  fpd_pkg::res_t out_res_r;
  fpd_pkg::cfg_t cfg_r;
  fpd_pkg::res_t step_res;
  logic          advance;
  logic          cfg_wr;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r    <= in_tdata;
      in_restart_r <= in_tuser[0];
    end
  end

  fpd_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_byte_r),
    .restart (in_restart_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.event_kind;
  assign out_tdata  = {2'b00, out_res_r.frame_length, out_res_r.frame_type,
                       out_res_r.payload_index, out_res_r.payload_byte};

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        fpd_pkg::REG_HEADER: cfg_r.header_word <= cfg_pwdata[15:0];
        fpd_pkg::REG_FOOTER: cfg_r.footer_word <= cfg_pwdata[15:0];
        fpd_pkg::REG_SEED:   cfg_r.crc_seed    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      fpd_pkg::REG_HEADER: cfg_prdata = {16'h0000, cfg_r.header_word};
      fpd_pkg::REG_FOOTER: cfg_prdata = {16'h0000, cfg_r.footer_word};
      fpd_pkg::REG_SEED:   cfg_prdata = {16'h0000, cfg_r.crc_seed};
      default:             cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/fpd_parser.sv]
// Frame parser state and the per-byte step logic of the deframer.
// Depends on fpd_pkg for codes, types and the CRC update.
`default_nettype none

module fpd_parser #(
  parameter int BUFFER_BYTES = fpd_pkg::BUFFER_BYTES
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          restart,
  input  wire fpd_pkg::cfg_t cfg,
  output fpd_pkg::res_t      res
);

  localparam int MAX_LEN = BUFFER_BYTES - 2;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] hdr_win_r, hdr_win_nxt;
  logic [15:0] ftr_win_r, ftr_win_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [13:0] data_count_r, data_count_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [7:0]  type_r, type_nxt;

  logic [15:0] hdr_shift, len_shift, ftr_shift, bl_dec;
  logic        clear;

  assign hdr_shift = {hdr_win_r[7:0], rx_byte};
  assign len_shift = {decl_len_r[7:0], rx_byte};
  assign ftr_shift = {ftr_win_r[7:0], rx_byte};
  assign bl_dec    = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_win_nxt    = hdr_win_r;
    ftr_win_nxt    = ftr_win_r;
    bytes_left_nxt = bytes_left_r;
    data_count_nxt = data_count_r;
    decl_len_nxt   = decl_len_r;
    crc_nxt        = crc_r;
    tail_nxt       = tail_r;
    type_nxt       = type_r;
    res            = '0;
    clear          = 1'b0;
    if (restart) begin
      clear = 1'b1;
    end else begin
      unique case (phase_r)
        fpd_pkg::PH_HUNT: begin
          hdr_win_nxt = hdr_shift;
          if (hdr_shift == cfg.header_word) begin
            phase_nxt      = fpd_pkg::PH_LENGTH;
            bytes_left_nxt = 16'd2;
            data_count_nxt = '0;
            decl_len_nxt   = '0;
            crc_nxt        = cfg.crc_seed;
            tail_nxt       = '0;
            type_nxt       = '0;
          end
        end
        fpd_pkg::PH_LENGTH: begin
          decl_len_nxt   = len_shift;
          crc_nxt        = fpd_pkg::crc_feed(crc_r, rx_byte);
          bytes_left_nxt = bl_dec;
          if (bl_dec == 16'd0) begin
            if ({1'b0, len_shift} >= 17'(fpd_pkg::MIN_LENGTH) &&
                {1'b0, len_shift} <= 17'(MAX_LEN)) begin
              phase_nxt      = fpd_pkg::PH_DATA;
              bytes_left_nxt = len_shift;
              data_count_nxt = '0;
            end else begin
              res.event_kind   = fpd_pkg::EV_REJECTED;
              res.frame_length = len_shift;
              clear            = 1'b1;
            end
          end
        end
        fpd_pkg::PH_DATA: begin
          res.event_kind    = fpd_pkg::EV_PAYLOAD;
          res.payload_byte  = rx_byte;
          res.payload_index = data_count_r;
          if (bytes_left_r == decl_len_r) begin
            type_nxt = rx_byte;
          end
          if ({1'b0, bytes_left_r} + 17'd2 <= {1'b0, decl_len_r}) begin
            crc_nxt = fpd_pkg::crc_feed(crc_r, tail_r[15:8]);
          end
          tail_nxt       = {tail_r[7:0], rx_byte};
          data_count_nxt = data_count_r + 14'd1;
          bytes_left_nxt = bl_dec;
          if (bl_dec == 16'd0) begin
            phase_nxt      = fpd_pkg::PH_FOOTER;
            bytes_left_nxt = 16'd2;
          end
        end
        default: begin
          ftr_win_nxt    = ftr_shift;
          bytes_left_nxt = bl_dec;
          if (bl_dec == 16'd0) begin
            if (ftr_shift != cfg.footer_word) begin
              res.event_kind = fpd_pkg::EV_FOOTER;
            end else if (crc_r != tail_r) begin
              res.event_kind = fpd_pkg::EV_CRC;
            end else begin
              res.event_kind = fpd_pkg::EV_GOOD;
            end
            res.frame_type   = type_r;
            res.frame_length = decl_len_r;
            clear            = 1'b1;
          end
        end
      endcase
    end
    if (clear) begin
      phase_nxt      = fpd_pkg::PH_HUNT;
      hdr_win_nxt    = '0;
      ftr_win_nxt    = '0;
      bytes_left_nxt = 16'd2;
      data_count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= fpd_pkg::PH_HUNT;
      hdr_win_r    <= '0;
      ftr_win_r    <= '0;
      bytes_left_r <= 16'd2;
      data_count_r <= '0;
      decl_len_r   <= '0;
      crc_r        <= '0;
      tail_r       <= '0;
      type_r       <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      hdr_win_r    <= hdr_win_nxt;
      ftr_win_r    <= ftr_win_nxt;
      bytes_left_r <= bytes_left_nxt;
      data_count_r <= data_count_nxt;
      decl_len_r   <= decl_len_nxt;
      crc_r        <= crc_nxt;
      tail_r       <= tail_nxt;
      type_r       <= type_nxt;
    end
  end

endmodule

`default_nettype wire
